[hw/rtl/totb_pkg.sv]
// ----------------------------------------------------------------------------
// totb_pkg - shared types and constants of the tick timer bank
// field widths, action and status codes, and the command sent to the cells
// ----------------------------------------------------------------------------
package totb_pkg;

  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned HANDLE_W    = CNT_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK       = 3'd0,
    ACT_REGISTER   = 3'd1,
    ACT_START      = 3'd2,
    ACT_STOP       = 3'd3,
    ACT_SET_PERIOD = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_PERIOD = 2'd1,
    STATUS_FULL       = 2'd2,
    STATUS_UNREG      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    COP_NONE,
    COP_REGISTER,
    COP_START,
    COP_STOP,
    COP_SET_PERIOD
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [SLOT_W-1:0]     slot;
    logic [PERIOD_W-1:0]   period;
  } cell_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic                fired;
    logic [SLOT_W-1:0]   fired_index;
    logic                last;
  } result_t;

endpackage

[hw/rtl/totb_in_if.sv]
// ----------------------------------------------------------------------------
// totb_in_if - request channel of the tick timer bank
// valid/ready handshake carrying one action with its slot and period
// ----------------------------------------------------------------------------
interface totb_in_if;
  import totb_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [SLOT_W-1:0]   timer_index;
  logic [PERIOD_W-1:0] period;

  modport source (output valid, output action, output timer_index, output period,
                  input ready);
  modport sink   (input valid, input action, input timer_index, input period,
                  output ready);
endinterface

[hw/rtl/totb_out_if.sv]
// ----------------------------------------------------------------------------
// totb_out_if - result channel of the tick timer bank
// valid/ready handshake carrying one status or expiry report
// ----------------------------------------------------------------------------
interface totb_out_if;
  import totb_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle;
  logic                fired;
  logic [SLOT_W-1:0]   fired_index;
  logic                last;

  modport source (output valid, output status, output handle, output fired,
                  output fired_index, output last, input ready);
  modport sink   (input valid, input status, input handle, input fired,
                  input fired_index, input last, output ready);
endinterface

[hw/rtl/tick_one_shot_timer_bank.sv]
// ----------------------------------------------------------------------------
// tick_one_shot_timer_bank - bank of one-shot tick timers
// a row of timer cells walked by a token on every tick, plus the sequencer
// ----------------------------------------------------------------------------
// usage
//   in_i  : one transfer per action (tick, register, start, stop, set period)
//   out_o : result transfers; every action ends with a transfer that has last
//           set, a tick gives one transfer per expired timer in slot order,
//           or a single empty transfer when nothing expired
// request acceptance and sequencing
//   a request is taken whenever the sequencer is idle, even while an earlier
//   result still sits in the output register
//   register, start, stop, set period: the execute state stores the result
//   tick: the token walks the 16 cells one cell per cycle while the output
//   is not stalled, then a closing transfer follows; a new request is taken
//   only after the walk is over
// stalls
//   while the output register is full and out_o.ready is low, the sequencer
//   and the walk hold still; no result is dropped
// reset
//   asynchronous, active low; all slots unregistered, stopped, counts zero
// ----------------------------------------------------------------------------
module tick_one_shot_timer_bank (
  input logic        clk_i,
  input logic        rst_ni,
  totb_in_if.sink    in_i,
  totb_out_if.source out_o
);
  import totb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK
  } state_e;

  state_e              state_q, state_d;

  // latched request
  logic [ACT_W-1:0]    act_q, act_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [PERIOD_W-1:0] per_q, per_d;

  logic [CNT_W-1:0]    reg_cnt_q, reg_cnt_d;

  // walk bookkeeping: token launch, position, one held-back expiry report
  logic                start_q, start_d;
  logic [SLOT_W-1:0]   pos_q, pos_d;
  logic                pend_q, pend_d;
  logic [SLOT_W-1:0]   pend_idx_q, pend_idx_d;

  // output register
  logic                out_valid_q, out_valid_d;
  result_t             res_q, res_d;

  logic                in_xfer;
  logic                can_push;
  logic                step_en;
  cell_cmd_t           cmd;
  logic [TIMER_SLOTS:0]   chain;
  logic [TIMER_SLOTS-1:0] fire;
  logic                fire_any;
  logic                walk_done;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign can_push   = !out_valid_q || out_o.ready;
  assign step_en    = (state_q == ST_WALK) && can_push;
  assign chain[0]   = start_q;
  assign fire_any   = |fire;
  assign walk_done  = chain[TIMER_SLOTS];

  // row of timer cells, token moves one cell to the right per step
  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    totb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .slot_id_i (SLOT_W'(g)),
      .cmd_i     (cmd),
      .step_i    (step_en),
      .tok_i     (chain[g]),
      .tok_o     (chain[g+1]),
      .fire_o    (fire[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    idx_d       = idx_q;
    per_d       = per_q;
    reg_cnt_d   = reg_cnt_q;
    start_d     = start_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    cmd.op      = COP_NONE;
    cmd.slot    = idx_q;
    cmd.period  = per_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          act_d = in_i.action;
          idx_d = in_i.timer_index;
          per_d = in_i.period;
          if (in_i.action == ACT_TICK) begin
            state_d = ST_WALK;
            start_d = 1'b1;
            pos_d   = '0;
            pend_d  = 1'b0;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        if (can_push) begin
          out_valid_d       = 1'b1;
          res_d.status      = STATUS_OK;
          res_d.handle      = '0;
          res_d.fired       = 1'b0;
          res_d.fired_index = '0;
          res_d.last        = 1'b1;
          state_d           = ST_IDLE;
          unique case (act_q)
            ACT_REGISTER: begin
              if (per_q == '0) begin
                res_d.status = STATUS_BAD_PERIOD;
              end else if (reg_cnt_q >= CNT_W'(TIMER_SLOTS)) begin
                res_d.status = STATUS_FULL;
              end else begin
                cmd.op       = COP_REGISTER;
                cmd.slot     = reg_cnt_q[SLOT_W-1:0];
                reg_cnt_d    = CNT_W'(reg_cnt_q + 1'b1);
                res_d.handle = CNT_W'(reg_cnt_q + 1'b1);
              end
            end
            ACT_START, ACT_STOP, ACT_SET_PERIOD: begin
              if (CNT_W'(idx_q) >= reg_cnt_q) begin
                res_d.status = STATUS_UNREG;
              end else if (act_q == ACT_START) begin
                cmd.op = COP_START;
              end else if (act_q == ACT_STOP) begin
                cmd.op = COP_STOP;
              end else begin
                cmd.op = COP_SET_PERIOD;
              end
            end
            default: begin
              // unused codes answer ok and change nothing
            end
          endcase
        end
      end

      ST_WALK: begin
        if (can_push) begin
          if (walk_done) begin
            // closing transfer: the held-back expiry, or an empty report
            out_valid_d       = 1'b1;
            res_d.status      = STATUS_OK;
            res_d.handle      = '0;
            res_d.fired       = pend_q;
            res_d.fired_index = pend_q ? pend_idx_q : '0;
            res_d.last        = 1'b1;
            pend_d            = 1'b0;
            state_d           = ST_IDLE;
          end else begin
            start_d = 1'b0;
            pos_d   = pos_q + 1'b1;
            if (fire_any) begin
              // a newer expiry proves the held one is not the last
              if (pend_q) begin
                out_valid_d       = 1'b1;
                res_d.status      = STATUS_OK;
                res_d.handle      = '0;
                res_d.fired       = 1'b1;
                res_d.fired_index = pend_idx_q;
                res_d.last        = 1'b0;
              end
              pend_d     = 1'b1;
              pend_idx_d = pos_q;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= '0;
      idx_q       <= '0;
      per_q       <= '0;
      reg_cnt_q   <= '0;
      start_q     <= 1'b0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      idx_q       <= idx_d;
      per_q       <= per_d;
      reg_cnt_q   <= reg_cnt_d;
      start_q     <= start_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = res_q.status;
  assign out_o.handle      = res_q.handle;
  assign out_o.fired       = res_q.fired;
  assign out_o.fired_index = res_q.fired_index;
  assign out_o.last        = res_q.last;

  // the walk token sits in at most one place of the row
  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain))
    else $error("walk token duplicated");

  // only expiry reports may leave last low
  a_last_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.fired |-> res_q.last)
    else $error("non-expiry result without last");

  // the registration table never overflows
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reg_cnt_q <= CNT_W'(TIMER_SLOTS))
    else $error("registered count beyond table size");

  // an expiry report always carries ok status
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.fired |-> res_q.status == STATUS_OK)
    else $error("expiry with error status");

endmodule

[hw/rtl/totb_cell.sv]
// ----------------------------------------------------------------------------
// totb_cell - one timer slot of the bank
// holds count, period and flags; ticks when the walk token passes through it
// while the slot is registered and running
module totb_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [totb_pkg::SLOT_W-1:0]  slot_id_i,
  input  totb_pkg::cell_cmd_t          cmd_i,
  input  logic                         step_i,
  input  logic                         tok_i,
  output logic                         tok_o,
  output logic                         fire_o
);
  import totb_pkg::*;

  logic                reg_q, reg_d;
  logic                run_q, run_d;
  logic [PERIOD_W-1:0] cnt_q, cnt_d;
  logic [PERIOD_W-1:0] per_q, per_d;
  logic [PERIOD_W-1:0] cnt_inc;
  logic                tok_q;
  logic                hit;
  logic                visit;

  assign hit     = (cmd_i.op != COP_NONE) && (cmd_i.slot == slot_id_i);
  assign visit   = step_i && tok_i && reg_q && run_q;
  assign cnt_inc = cnt_q + 1'b1;
  assign fire_o  = visit && (cnt_inc >= per_q);
  assign tok_o   = tok_q;

  always_comb begin
    reg_d = reg_q;
    run_d = run_q;
    cnt_d = cnt_q;
    per_d = per_q;
    if (visit) begin
      if (fire_o) begin
        cnt_d = '0;
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_inc;
      end
    end else if (hit) begin
      unique case (cmd_i.op)
        COP_REGISTER: begin
          reg_d = 1'b1;
          run_d = 1'b0;
          cnt_d = '0;
          per_d = cmd_i.period;
        end
        COP_START: begin
          run_d = 1'b1;
          cnt_d = '0;
        end
        COP_STOP: begin
          run_d = 1'b0;
          cnt_d = '0;
        end
        COP_SET_PERIOD: begin
          per_d = cmd_i.period;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= 1'b0;
      run_q <= 1'b0;
      cnt_q <= '0;
      tok_q <= 1'b0;
    end else begin
      reg_q <= reg_d;
      run_q <= run_d;
      cnt_q <= cnt_d;
      if (step_i) begin
        tok_q <= tok_i;
      end
    end
  end

  // period has no reset value, only registered slots are ever compared
  always_ff @(posedge clk_i) begin
    per_q <= per_d;
  end

endmodule
